// ===== src/sas_pkg.sv =====
// Package for the safety arming supervisor: types, codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none
package sas_pkg;

	localparam int unsigned FLAG_W = 5;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned HOLD_W = 16;
	localparam int unsigned CODE_W = 3;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ST_BOOT_LOCKED = 2'd0,
		ST_DISARMED    = 2'd1,
		ST_ARMED       = 2'd2,
		ST_FAULT       = 2'd3
	} arm_state_t;

	typedef logic [CODE_W-1:0] fault_code_t;

	localparam fault_code_t FC_NONE        = 3'd0;
	localparam fault_code_t FC_SENSOR      = 3'd1;
	localparam fault_code_t FC_STALL       = 3'd2;
	localparam fault_code_t FC_RUNTIME     = 3'd3;
	localparam fault_code_t FC_NO_FEEDBACK = 3'd4;
	localparam fault_code_t FC_OVERSPEED   = 3'd5;
	localparam fault_code_t FC_CONFIG      = 3'd6;

	typedef struct packed {
		logic [FLAG_W-1:0] fault_flags;
		logic              outputs_enabled;
		logic              calibration_confirmed;
		logic              settings_valid;
		logic              remote_stop;
		logic              command_valid;
		logic              brake_requested;
		logic              throttle_neutral;
		logic [TIME_W-1:0] now_ms;
	} tick_t;

	typedef struct packed {
		fault_code_t       fault;
		arm_state_t        mode;
		logic              timing;
		logic [TIME_W-1:0] start_ms;
	} sup_state_t;

	typedef struct packed {
		arm_state_t  state;
		fault_code_t code;
		logic        drive_enable;
		logic        force_neutral;
	} result_t;

endpackage
`default_nettype wire

// ===== src/sas_decide.sv =====
// Combinational arming decision: one tick against the current supervisor state.
`timescale 1ns / 1ps
`default_nettype none
module sas_decide (
	input  sas_pkg::tick_t                  tick,
	input  sas_pkg::sup_state_t             cur,
	input  logic [sas_pkg::HOLD_W-1:0]      hold_ms,
	output sas_pkg::sup_state_t             nxt,
	output sas_pkg::result_t                res
);

	sas_pkg::fault_code_t        fault;
	logic [sas_pkg::TIME_W-1:0]  start;
	logic [sas_pkg::TIME_W-1:0]  elapsed;
	logic                        stop;

	always_comb begin
		fault = cur.fault;
		if (fault == sas_pkg::FC_NONE) begin
			if (tick.fault_flags[0])
				fault = sas_pkg::FC_SENSOR;
			else if (tick.fault_flags[1])
				fault = sas_pkg::FC_STALL;
			else if (tick.fault_flags[2])
				fault = sas_pkg::FC_RUNTIME;
			else if (tick.fault_flags[3])
				fault = sas_pkg::FC_NO_FEEDBACK;
			else if (tick.fault_flags[4])
				fault = sas_pkg::FC_OVERSPEED;
			else if (tick.outputs_enabled &&
			         (!tick.calibration_confirmed || !tick.settings_valid))
				fault = sas_pkg::FC_CONFIG;
		end
	end

	// Restart the neutral window on its first tick, so elapsed is zero then.
	assign start   = cur.timing ? cur.start_ms : tick.now_ms;
	assign elapsed = tick.now_ms - start;
	assign stop    = tick.remote_stop || !tick.command_valid || tick.brake_requested;

	always_comb begin
		nxt = cur;
		res.state         = sas_pkg::ST_DISARMED;
		res.code          = sas_pkg::FC_NONE;
		res.drive_enable  = 1'b0;
		res.force_neutral = 1'b0;
		if (fault != sas_pkg::FC_NONE) begin
			nxt.fault         = fault;
			nxt.mode          = sas_pkg::ST_FAULT;
			nxt.timing        = 1'b0;
			res.state         = sas_pkg::ST_FAULT;
			res.code          = fault;
			res.force_neutral = 1'b1;
		end else if (!tick.outputs_enabled) begin
			nxt.mode          = sas_pkg::ST_BOOT_LOCKED;
			nxt.timing        = 1'b0;
			res.state         = sas_pkg::ST_BOOT_LOCKED;
			res.force_neutral = 1'b1;
		end else if (stop) begin
			nxt.mode          = sas_pkg::ST_DISARMED;
			nxt.timing        = 1'b0;
			res.force_neutral = 1'b1;
		end else if (cur.mode == sas_pkg::ST_ARMED) begin
			res.state        = sas_pkg::ST_ARMED;
			res.drive_enable = 1'b1;
		end else if (!tick.throttle_neutral) begin
			nxt.mode   = sas_pkg::ST_DISARMED;
			nxt.timing = 1'b0;
		end else if (elapsed >= {{(sas_pkg::TIME_W-sas_pkg::HOLD_W){1'b0}}, hold_ms}) begin
			nxt.mode         = sas_pkg::ST_ARMED;
			nxt.timing       = 1'b0;
			nxt.start_ms     = start;
			res.state        = sas_pkg::ST_ARMED;
			res.drive_enable = 1'b1;
		end else begin
			nxt.mode     = sas_pkg::ST_DISARMED;
			nxt.timing   = 1'b1;
			nxt.start_ms = start;
		end
	end

endmodule
`default_nettype wire

// ===== src/safety_arming_supervisor.sv =====
// Top level of the safety arming supervisor: input stage, state, result register.
`timescale 1ns / 1ps
`default_nettype none
// Timing: a tick is held in the input stage register, then its result loads
//   into the result register once that register can accept it; the state
//   update lands in the same edge as the result.
// Throughput: one tick per cycle unless out_stall holds the single-entry result register.
// Reset (arst_n low, asynchronous): boot locked, no fault, neutral timer idle,
//   hold time 1000 ms, both pipeline stages empty.
module safety_arming_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  fault_flags,
	input  logic        outputs_enabled,
	input  logic        calibration_confirmed,
	input  logic        settings_valid,
	input  logic        remote_stop,
	input  logic        command_valid,
	input  logic        brake_requested,
	input  logic        throttle_neutral,
	input  logic [31:0] now_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  arming_state,
	output logic [2:0]  fault_code,
	output logic        drive_enable,
	output logic        force_neutral,
	// hold time register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	sas_pkg::tick_t      tick_in;
	sas_pkg::tick_t      tick_s1;
	logic                valid_s1;
	sas_pkg::result_t    res_s2;
	logic                valid_s2;
	sas_pkg::sup_state_t st_q;
	sas_pkg::sup_state_t st_nxt;
	sas_pkg::result_t    res_nxt;
	logic [15:0]         hold_q;
	logic                advance;
	logic                load_s1;

	// Register writes always complete; the user must change configuration only while idle (not enforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_q <= sas_pkg::HOLD_RESET;
		else if (cfg_valid && cfg_ready)
			hold_q <= cfg_data;
	end

	// Pack the input fields into one tick.
	assign tick_in.fault_flags           = fault_flags;
	assign tick_in.outputs_enabled       = outputs_enabled;
	assign tick_in.calibration_confirmed = calibration_confirmed;
	assign tick_in.settings_valid        = settings_valid;
	assign tick_in.remote_stop           = remote_stop;
	assign tick_in.command_valid         = command_valid;
	assign tick_in.brake_requested       = brake_requested;
	assign tick_in.throttle_neutral      = throttle_neutral;
	assign tick_in.now_ms                = now_ms;

	// Advance the input stage whenever the result register is empty or drains
	// this cycle; stall the input side only while a held tick cannot advance.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			tick_s1 <= tick_in;
	end

	sas_decide u_decide (
		.tick    (tick_s1),
		.cur     (st_q),
		.hold_ms (hold_q),
		.nxt     (st_nxt),
		.res     (res_nxt)
	);

	// Commit the supervisor state exactly once per tick, as it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.fault    <= sas_pkg::FC_NONE;
			st_q.mode     <= sas_pkg::ST_BOOT_LOCKED;
			st_q.timing   <= 1'b0;
			st_q.start_ms <= '0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register: hold while stalled, refill or drop when it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_s2 <= res_nxt;
	end

	assign out_valid     = valid_s2;
	assign arming_state  = res_s2.state;
	assign fault_code    = res_s2.code;
	assign drive_enable  = res_s2.drive_enable;
	assign force_neutral = res_s2.force_neutral;

`ifndef NO_ASSERTIONS
	// A latched fault never changes until reset.
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.fault != sas_pkg::FC_NONE) |=> (st_q.fault == $past(st_q.fault)))
		else $error("latched fault changed");

	// The fault mode and a nonzero latched code go together.
	a_fault_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == sas_pkg::ST_FAULT) == (st_q.fault != sas_pkg::FC_NONE))
		else $error("fault mode and latched code disagree");

	// Drive is only enabled in the armed state, never with forced neutral.
	a_drive_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.drive_enable) |->
			(res_s2.state == sas_pkg::ST_ARMED && !res_s2.force_neutral))
		else $error("drive enabled outside armed state");

	// A tick held in stage 1 stays there while the result side is blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(tick_s1)))
		else $error("stage 1 tick lost while stalled");
`endif

endmodule
`default_nettype wire
